[rtl/fde_pkg.sv]
`default_nettype none

package fde_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 131072;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 24;

  // Register field widths
  localparam int unsigned DLY_W      = 17;
  localparam int unsigned FB_W       = 16;
  localparam int unsigned MIX_W      = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // Q0.16 fb, Q1.16 mix gains
  localparam int unsigned     FRAC_W     = 16;
  localparam int unsigned     ROUND_HALF = 32768;
  localparam logic [MIX_W-1:0] GAIN_ONE  = 17'h10000;
  localparam logic [FB_W-1:0]  FB_MAX    = 16'd65470;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_MIX      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [FB_W-1:0]  fb;
    logic [MIX_W-1:0] wet;
    logic [MIX_W-1:0] dry;
  } gain_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic ld2;
    logic ld3;
    logic fwd;
    logic tap_ok;
    logic zero_dly;
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/fde_stream_if.sv]
`default_nettype none

interface fde_in_if #(
  parameter int unsigned SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface fde_out_if #(
  parameter int unsigned SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

[rtl/fde_cfg.sv]
`default_nettype none

module fde_cfg #(
  parameter int unsigned DEPTH = fde_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fde_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output fde_pkg::gain_t                  gain_o,
  output logic [$clog2(DEPTH)-1:0]        dly_o,
  output logic                            busy_o
);
  import fde_pkg::*;

  localparam int unsigned AW     = $clog2(DEPTH);
  // Reduce the delay modulo DEPTH: estimate the quotient by a reciprocal
  // multiply, then fix the remainder with one compare and subtract.
  // Nothing to do once DEPTH covers the whole delay field.
  localparam bit               REDUCE  = (DEPTH < (1 << DLY_W));
  localparam int unsigned      PW      = 2 * DLY_W;
  localparam logic [DLY_W-1:0] RECIP   = REDUCE ? DLY_W'((1 << DLY_W) / DEPTH) : '0;
  localparam logic [DLY_W:0]   DEPTH_C = REDUCE ? (DLY_W+1)'(DEPTH) : '0;
  localparam logic [1:0]       RED_CYC = REDUCE ? 2'd2 : 2'd0;

  logic [DLY_W-1:0] raw_q;
  logic [DLY_W-1:0] rem_q;
  logic [DLY_W-1:0] quo_q;
  logic [1:0]       cnt_q;
  logic [PW-1:0]    quo_est;
  logic [PW-1:0]    quo_prod;
  logic [DLY_W:0]   rem_raw;
  logic [DLY_W:0]   rem_fix;
  gain_t            gain_q;
  logic [FB_W-1:0]  fb_val;
  logic [MIX_W-1:0] wet_val;

  assign fb_val  = (cfg_data_i[FB_W-1:0] > FB_MAX) ? FB_MAX : cfg_data_i[FB_W-1:0];
  assign wet_val = (MIX_W'(cfg_data_i) > GAIN_ONE) ? GAIN_ONE : MIX_W'(cfg_data_i);

  // Estimate falls short of the true quotient by at most one
  assign quo_est  = PW'(raw_q) * PW'(RECIP);
  assign quo_prod = PW'(quo_q) * PW'(DEPTH_C);
  assign rem_raw  = (DLY_W+1)'(raw_q) - quo_prod[DLY_W:0];
  assign rem_fix  = (rem_raw >= DEPTH_C) ? rem_raw - DEPTH_C : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      gain_q <= '{fb: '0, wet: '0, dry: GAIN_ONE};
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_DELAY) begin
        raw_q <= cfg_data_i[DLY_W-1:0];
        rem_q <= cfg_data_i[DLY_W-1:0];
        cnt_q <= RED_CYC;
      end else if (cnt_q == 2'd2) begin
        quo_q <= quo_est[PW-1:DLY_W];
        cnt_q <= 2'd1;
      end else if (cnt_q == 2'd1) begin
        rem_q <= rem_fix[DLY_W-1:0];
        cnt_q <= 2'd0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FEEDBACK: begin
            gain_q.fb <= fb_val;
          end
          REG_MIX: begin
            gain_q.wet <= wet_val;
            gain_q.dry <= GAIN_ONE - wet_val;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign gain_o = gain_q;
  assign dly_o  = AW'(rem_q);
  assign busy_o = (cnt_q != '0);

endmodule

`default_nettype wire

[rtl/fde_lane.sv]
`default_nettype none

module fde_lane #(
  parameter int unsigned DEPTH       = fde_pkg::DEPTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  fde_pkg::lane_ctl_t            ctl_i,
  input  fde_pkg::gain_t                gain_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  output logic signed [SAMPLE_BITS-1:0] res_o
);
  import fde_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned PW = SW + FB_W + 1;
  localparam int unsigned MW = SW + MIX_W + 1;

  logic signed [SW-1:0] mem [DEPTH];

  logic signed [SW-1:0] in_s1_q, rd_q, fwd_q;
  logic signed [SW-1:0] tap, wr_val, mtap;
  logic signed [SW-1:0] in_s2_q, mt_s2_q;
  logic signed [PW-1:0] fb_prod, fb_bias;
  logic signed [SW:0]   fb_rnd;
  logic signed [SW+1:0] fb_sum;
  logic signed [MW-1:0] dry_prod, wet_prod, dry_p_q, wet_p_q;
  logic signed [MW:0]   mix_sum;
  logic signed [SW+2:0] mix_rnd;

  // Feedback: stored tap, the value just leaving this stage, or zero
  assign tap     = ctl_i.fwd ? fwd_q : (ctl_i.tap_ok ? rd_q : '0);
  assign fb_prod = tap * $signed({1'b0, gain_i.fb});
  assign fb_bias = fb_prod + $signed(PW'(ROUND_HALF));
  assign fb_rnd  = fb_bias[PW-1:FRAC_W];
  assign fb_sum  = (SW+2)'(in_s1_q) + (SW+2)'(fb_rnd);

  always_comb begin
    if (fb_sum[SW+1:SW-1] == '0 || fb_sum[SW+1:SW-1] == '1) begin
      wr_val = fb_sum[SW-1:0];
    end else if (fb_sum[SW+1]) begin
      wr_val = {1'b1, {(SW-1){1'b0}}};
    end else begin
      wr_val = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Zero delay: mix the value written this cycle
  assign mtap = ctl_i.zero_dly ? wr_val : tap;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_val;
    end
    if (ctl_i.rd_en) begin
      rd_q    <= mem[rd_addr_i];
      in_s1_q <= in_i;
      fwd_q   <= wr_val;
    end
    if (ctl_i.ld2) begin
      in_s2_q <= in_s1_q;
      mt_s2_q <= mtap;
    end
    if (ctl_i.ld3) begin
      dry_p_q <= dry_prod;
      wet_p_q <= wet_prod;
    end
  end

  assign dry_prod = $signed({1'b0, gain_i.dry}) * in_s2_q;
  assign wet_prod = $signed({1'b0, gain_i.wet}) * mt_s2_q;
  assign mix_sum  = (MW+1)'(dry_p_q) + (MW+1)'(wet_p_q) + $signed((MW+1)'(ROUND_HALF));
  assign mix_rnd  = mix_sum[MW:FRAC_W];

  always_comb begin
    if (mix_rnd[SW+2:SW-1] == '0 || mix_rnd[SW+2:SW-1] == '1) begin
      res_o = mix_rnd[SW-1:0];
    end else if (mix_rnd[SW+2]) begin
      res_o = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[rtl/feedback_delay_echo_core.sv]
`default_nettype none

// Stereo feedback echo, one stereo beat per cycle sustained while the output is
// ready and no delay write is being reduced. A result beat passes S1, S2, S3
// and the output register after its input beat is accepted. A delay register
// write holds input ready low while the delay is reduced modulo DEPTH (none
// when DEPTH >= 131072). Reset: control registers clear at once; the stores are
// not swept; a write pointer and wrap flag make unwritten entries read as zero.
module feedback_delay_echo_core #(
  parameter int unsigned DEPTH       = fde_pkg::DEPTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fde_in_if.sink                         in_i,
  fde_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [fde_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fde_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fde_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned AW1 = AW + 1;

  gain_t                   gain;
  logic [AW-1:0]           dly;
  logic                    busy;

  // Write position and fill tracking
  logic [AW-1:0]           wp_q;
  logic                    wrap_q;
  logic [AW-1:0]           wp_nxt;
  logic [AW:0]             rd_diff;
  logic [AW-1:0]           rd_addr;

  // Stage occupancy: S1 (tap, feedback), S2 (mix products), S3 (sum), output
  logic                    v1_q, v2_q, v3_q, vo_q;
  logic                    s1_fwd_q, s1_tok_q, s1_zero_q;
  logic [AW-1:0]           wp_s1_q;
  logic                    accept, go_o;
  logic                    adv1, adv2, adv3;
  logic                    free1, free2, free3;
  lane_ctl_t               lane_ctl;

  logic signed [SAMPLE_BITS-1:0] res_l, res_r;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;

  fde_cfg #(
    .DEPTH (DEPTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .gain_o     (gain),
    .dly_o      (dly),
    .busy_o     (busy)
  );

  // Each stage moves when the stage after it is free or moving too, so a
  // bubble anywhere lets a new beat in even while a result waits downstream.
  assign go_o  = !vo_q || out_o.ready;
  assign adv3  = v3_q && go_o;
  assign free3 = !v3_q || go_o;
  assign adv2  = v2_q && free3;
  assign free2 = !v2_q || free3;
  assign adv1  = v1_q && free2;
  assign free1 = !v1_q || free2;

  assign in_i.ready = free1 && !busy;
  assign accept     = in_i.valid && in_i.ready;

  // Read position trails the write position by the reduced delay
  assign rd_diff = {1'b0, wp_q} - {1'b0, dly};
  assign rd_addr = rd_diff[AW] ? AW'(rd_diff + AW1'(DEPTH)) : rd_diff[AW-1:0];
  assign wp_nxt  = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrap_q    <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vo_q      <= 1'b0;
      s1_fwd_q  <= 1'b0;
      s1_tok_q  <= 1'b0;
      s1_zero_q <= 1'b0;
    end else begin
      v1_q <= accept || (v1_q && !adv1);
      v2_q <= adv1 || (v2_q && !adv2);
      v3_q <= adv2 || (v3_q && !adv3);
      vo_q <= adv3 || (vo_q && !out_o.ready);
      if (accept) begin
        wp_q <= wp_nxt;
        if (wp_q == AW'(DEPTH - 1)) begin
          wrap_q <= 1'b1;
        end
        // The beat leaving S1 on this edge writes after our read: forward it
        // when it sits exactly one position behind.
        s1_fwd_q  <= (dly == AW'(1)) && adv1;
        // Entry holds a written value once the pointer has passed it
        s1_tok_q  <= wrap_q || (dly != '0 && !rd_diff[AW]);
        s1_zero_q <= (dly == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wp_s1_q <= wp_q;
    end
  end

  always_comb begin
    lane_ctl          = '0;
    lane_ctl.rd_en    = accept;
    lane_ctl.wr_en    = adv1;
    lane_ctl.ld2      = adv1;
    lane_ctl.ld3      = adv2;
    lane_ctl.fwd      = s1_fwd_q;
    lane_ctl.tap_ok   = s1_tok_q;
    lane_ctl.zero_dly = s1_zero_q;
  end

  fde_lane #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i     (clk_i),
    .ctl_i     (lane_ctl),
    .gain_i    (gain),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wp_s1_q),
    .in_i      (in_i.in_left),
    .res_o     (res_l)
  );

  fde_lane #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i     (clk_i),
    .ctl_i     (lane_ctl),
    .gain_i    (gain),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wp_s1_q),
    .in_i      (in_i.in_right),
    .res_o     (res_r)
  );

  // Merge both lanes into one output beat; hold it until taken
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_l_q <= res_l;
      out_r_q <= res_r;
    end
  end

  assign out_o.valid     = vo_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;

`ifndef SYNTHESIS
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted beat did not reach S1");

  a_out_from_s3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vo_q) |-> $past(v3_q))
    else $error("output register loaded without a beat in S3");

  a_fwd_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && s1_fwd_q |-> v2_q)
    else $error("forwarded tap without its source beat in S2");

  a_wp_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && wp_q == AW'(DEPTH - 1) |=> wrap_q && wp_q == '0)
    else $error("write position wrap mishandled");
`endif

endmodule

`default_nettype wire
